/* rtl/unstp_pkg.sv */
// Shared types and constants of the unsigned number text parser.
`timescale 1ns / 1ps
package unstp_pkg;

    localparam int OUT_POS_W   = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;
    localparam logic [5:0] LETTER_OFS = 6'd10;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_PEND,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    // Classified character as it travels from the front to the back.
    typedef struct packed {
        logic       first;
        logic [5:0] base_req;
        logic       is_digit;
        logic [5:0] digit;
        logic       is_ws;
        logic       is_zero;
        logic       is_x;
    } item_t;

endpackage

/* rtl/unstp_front.sv */
// Front end: accepts character transactions and classifies each byte.
`timescale 1ns / 1ps
module unstp_front (
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          ch,
    input  logic                first,
    input  logic [5:0]          base_req,
    input  logic                q_full,
    output logic                push,
    output unstp_pkg::item_t    item
);
    import unstp_pkg::*;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        item.first    = first;
        item.base_req = base_req;
        item.is_ws    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL);
        item.is_zero  = (ch == CH_ZERO);
        item.is_x     = (ch == CH_LX) || (ch == CH_UX);
        item.is_digit = 1'b1;
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            item.digit = 6'(ch - CH_ZERO);
        end
        else if (ch >= CH_LA && ch <= CH_LZ)
        begin
            item.digit = 6'(ch - CH_LA) + LETTER_OFS;
        end
        else if (ch >= CH_UA && ch <= CH_UZ)
        begin
            item.digit = 6'(ch - CH_UA) + LETTER_OFS;
        end
        else
        begin
            item.digit    = '0;
            item.is_digit = 1'b0;
        end
    end

endmodule

/* rtl/unstp_queue.sv */
// Short queue of classified characters between the front and the back.
`timescale 1ns / 1ps
module unstp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  unstp_pkg::item_t    item_in,
    output logic                full,
    input  logic                pop,
    output logic                q_valid,
    output unstp_pkg::item_t    item_out
);
    import unstp_pkg::*;

    item_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign item_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

/* rtl/unstp_back.sv */
// Back end: parse state machine, accumulator and output register.
`timescale 1ns / 1ps
module unstp_back #(
    parameter int POS_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  unstp_pkg::item_t    item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [63:0]         value,
    output logic [15:0]         stop_offset,
    output logic                done_res,
    output logic [5:0]          base_used
);
    import unstp_pkg::*;

    localparam int EXT_W = (POS_WIDTH > OUT_POS_W) ? POS_WIDTH : OUT_POS_W;

    phase_t                 phase_reg, phase_next, e_phase;
    logic [5:0]             base_reg, base_next, e_base, base_mid;
    logic [63:0]            acc_reg, acc_next, e_acc, prod;
    logic [POS_WIDTH-1:0]   pos_reg, pos_next, e_pos, pos_inc;
    logic [EXT_W-1:0]       pos_ext;
    logic                   auto_or_hex, digit_ok, take, count_it;

    logic                   out_valid_reg;
    logic [63:0]            value_reg;
    logic [15:0]            offset_reg, offset_next;
    logic                   done_reg;
    logic [5:0]             base_used_reg;

    assign pop = q_valid && (!out_valid_reg || !out_stall);

    // Apply the start of a new string before the byte itself.
    always_comb
    begin
        e_phase = item.first ? PH_SKIP : phase_reg;
        e_base  = item.first ? item.base_req : base_reg;
        e_acc   = item.first ? '0 : acc_reg;
        e_pos   = item.first ? '0 : pos_reg;
    end

    assign auto_or_hex = (e_base == BASE_AUTO) || (e_base == BASE_HEX);
    assign pos_inc     = (e_pos == '1) ? e_pos : e_pos + 1'b1;

    always_comb
    begin
        case (e_phase)
            PH_SKIP:
            begin
                base_mid = (e_base == BASE_AUTO) ? BASE_DEC : e_base;
            end
            PH_PEND:
            begin
                if (e_base != BASE_AUTO)
                begin
                    base_mid = e_base;
                end
                else
                begin
                    base_mid = item.is_x ? BASE_HEX : BASE_OCT;
                end
            end
            default:
            begin
                base_mid = e_base;
            end
        endcase
    end

    assign digit_ok = item.is_digit && (item.digit < base_mid);

    // Next parse phase.
    always_comb
    begin
        case (e_phase)
            PH_SKIP:
            begin
                if (item.is_ws)
                begin
                    phase_next = PH_SKIP;
                end
                else if (item.is_zero && auto_or_hex)
                begin
                    phase_next = PH_PEND;
                end
                else
                begin
                    phase_next = digit_ok ? PH_DIGITS : PH_DONE;
                end
            end
            PH_PEND:
            begin
                if (item.is_x)
                begin
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    phase_next = digit_ok ? PH_DIGITS : PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                phase_next = digit_ok ? PH_DIGITS : PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // Datapath controls per phase.
    always_comb
    begin
        take     = 1'b0;
        count_it = 1'b0;
        case (e_phase)
            PH_SKIP:
            begin
                if (item.is_ws || (item.is_zero && auto_or_hex))
                begin
                    count_it = 1'b1;
                end
                else
                begin
                    take = 1'b1;
                end
            end
            PH_PEND:
            begin
                if (item.is_x)
                begin
                    count_it = 1'b1;
                end
                else
                begin
                    take = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                take = 1'b1;
            end
            default:
            begin
                take = 1'b0;
            end
        endcase
    end

    assign prod = e_acc * 64'(base_mid);

    always_comb
    begin
        base_next = (take || count_it) && (e_phase != PH_SKIP || take) ? base_mid : e_base;
        acc_next  = (take && digit_ok) ? prod + 64'(item.digit) : e_acc;
        pos_next  = (count_it || (take && digit_ok)) ? pos_inc : e_pos;
        pos_ext   = EXT_W'(pos_next);
        offset_next = ((pos_ext >> OUT_POS_W) != '0) ? '1 : pos_ext[OUT_POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            base_reg      <= '0;
            acc_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                base_reg  <= base_next;
                acc_reg   <= acc_next;
                pos_reg   <= pos_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            value_reg     <= acc_next;
            offset_reg    <= offset_next;
            done_reg      <= (phase_next == PH_DONE);
            base_used_reg <= (phase_next == PH_DIGITS || phase_next == PH_DONE) ? base_next : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign stop_offset = offset_reg;
    assign done_res    = done_reg;
    assign base_used   = base_used_reg;

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from an empty queue");

    a_done_has_base: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> (base_used_reg != '0))
        else $error("done result without an effective base");

    a_done_holds_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE && !(pop && item.first)) |=> (acc_reg == $past(acc_reg)))
        else $error("accumulator moved after parse finished");

    a_pos_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !item.first) |=> (pos_reg >= $past(pos_reg)))
        else $error("position decreased within a string");
`endif

endmodule

/* rtl/unsigned_number_text_parser_unit.sv */
// Top level of the unsigned number text parser.
// Usage:
//   Input channel (in_valid / in_stall) carries one character per transaction:
//   ch, first and base_req. first = 1 starts a new string with base base_req
//   (0 = auto: 0x -> 16, leading 0 -> 8, else 10).
//   Output channel (out_valid / out_stall) returns one result per character:
//   running value, stop_offset, done_res and base_used.
//   Throughput: one character per cycle while out_stall is low, set by the 64 x 6
//   bit multiply-add that updates the accumulator in the back end per character.
//   A character accepted into the queue is parsed from there into the output
//   register, which presents the result.
//   A two-entry queue separates classification from parsing, so input is
//   stalled only when the queue is full, which happens when the receiver
//   holds out_stall; results then wait in the output register.
//   Reset clears the queue, the output valid and the parse state (auto base).
`timescale 1ns / 1ps
module unsigned_number_text_parser_unit #(
    parameter int POS_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        first,
    input  logic [5:0]  base_req,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] value,
    output logic [15:0] stop_offset,
    output logic        done_res,
    output logic [5:0]  base_used
);
    import unstp_pkg::*;

    item_t  front_item;
    item_t  back_item;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;

    unstp_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ch       (ch),
        .first    (first),
        .base_req (base_req),
        .q_full   (q_full),
        .push     (push),
        .item     (front_item)
    );

    unstp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .item_out (back_item)
    );

    unstp_back #(
        .POS_WIDTH (POS_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .item        (back_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value),
        .stop_offset (stop_offset),
        .done_res    (done_res),
        .base_used   (base_used)
    );

endmodule

/* bench/unstp_parse_monitor.sv */
// Watches both channels of the number text parser, predicts each result and compares it.
`timescale 1ns / 1ps
module unstp_parse_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        first,
    input  logic [5:0]  base_req,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] value,
    input  logic [15:0] stop_offset,
    input  logic        done_res,
    input  logic [5:0]  base_used,
    output int          mismatches,
    output int          outstanding,
    output int          results_seen
);
    import unstp_pkg::*;

    localparam logic [7:0]  NOT_A_DIGIT = 8'hFF;
    localparam logic [15:0] OFFSET_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [63:0] value;
        logic [15:0] offset;
        logic        done;
        logic [5:0]  base;
    } parse_out_t;

    phase_t      scan_phase;
    logic [5:0]  scan_base;
    logic [63:0] scan_value;
    logic [15:0] scan_offset;
    parse_out_t  expected_parse [$];
    parse_out_t  want;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        mismatches++;
        $display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got, exp_val);
    endtask

    function automatic logic [7:0] digit_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return c - CH_ZERO;
        if (c >= CH_LA && c <= CH_LZ)
            return c - CH_LA + 8'(LETTER_OFS);
        if (c >= CH_UA && c <= CH_UZ)
            return c - CH_UA + 8'(LETTER_OFS);
        return NOT_A_DIGIT;
    endfunction

    function automatic void bump_offset();
        if (scan_offset != OFFSET_MAX)
            scan_offset++;
    endfunction

    function automatic void take_digit(input logic [7:0] c);
        logic [7:0] d;
        d = digit_of(c);
        if (d != NOT_A_DIGIT && d < {2'b00, scan_base})
        begin
            scan_value = scan_value * 64'(scan_base) + 64'(d);
            bump_offset();
            scan_phase = PH_DIGITS;
        end
        else
            scan_phase = PH_DONE;
    endfunction

    function automatic parse_out_t parse_char(input logic [7:0] c, input logic f,
                                              input logic [5:0] b);
        parse_out_t r;
        if (f)
        begin
            scan_phase  = PH_SKIP;
            scan_value  = '0;
            scan_offset = '0;
            scan_base   = b;
        end
        case (scan_phase)
            PH_SKIP:
                if (c == CH_SPACE || c == CH_TAB || c == CH_NL)
                    bump_offset();
                else if (c == CH_ZERO && (scan_base == BASE_AUTO || scan_base == BASE_HEX))
                begin
                    // hold the zero: it may open a 0x prefix
                    bump_offset();
                    scan_phase = PH_PEND;
                end
                else
                begin
                    if (scan_base == BASE_AUTO)
                        scan_base = BASE_DEC;
                    scan_phase = PH_DIGITS;
                    take_digit(c);
                end
            PH_PEND:
                if (c == CH_LX || c == CH_UX)
                begin
                    bump_offset();
                    if (scan_base == BASE_AUTO)
                        scan_base = BASE_HEX;
                    scan_phase = PH_DIGITS;
                end
                else
                begin
                    if (scan_base == BASE_AUTO)
                        scan_base = BASE_OCT;
                    scan_phase = PH_DIGITS;
                    take_digit(c);
                end
            PH_DIGITS:
                take_digit(c);
            default:
                ;
        endcase
        r.value  = scan_value;
        r.offset = scan_offset;
        r.done   = (scan_phase == PH_DONE);
        r.base   = (scan_phase == PH_DIGITS || scan_phase == PH_DONE) ? scan_base : BASE_AUTO;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_phase  = PH_SKIP;
            scan_base   = BASE_AUTO;
            scan_value  = '0;
            scan_offset = '0;
            expected_parse.delete();
        end
        else
        begin
            // retire the result first: it never belongs to this edge's input
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_parse.size() == 0)
                    report_mismatch("result with nothing expected", value, 64'd0);
                else
                begin
                    want = expected_parse.pop_front();
                    if (value !== want.value)
                        report_mismatch("value", value, want.value);
                    if (stop_offset !== want.offset)
                        report_mismatch("stop_offset", 64'(stop_offset), 64'(want.offset));
                    if (done_res !== want.done)
                        report_mismatch("done_res", 64'(done_res), 64'(want.done));
                    if (base_used !== want.base)
                        report_mismatch("base_used", 64'(base_used), 64'(want.base));
                end
            end
            if (in_valid && !in_stall)
                expected_parse.push_back(parse_char(ch, first, base_req));
        end
        outstanding = expected_parse.size();
    end

endmodule

/* bench/tb_unsigned_number_text_parser_unit.sv */
// Stimulus and verdict for the unsigned number text parser.
`timescale 1ns / 1ps
module tb_unsigned_number_text_parser_unit;
    import unstp_pkg::*;

    typedef enum int {
        IDLE_NONE,
        IDLE_FULL,
        IDLE_SPARSE
    } idle_mode_t;

    localparam int ROUND_ITEMS  = 240;
    localparam int DRAIN_CYCLES = 20;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  ch        = 8'h00;
    logic        first     = 1'b0;
    logic [5:0]  base_req  = BASE_AUTO;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] value;
    logic [15:0] stop_offset;
    logic        done_res;
    logic [5:0]  base_used;

    int          mismatches;
    int          outstanding;
    int          results_seen;

    idle_mode_t  idle_mode    = IDLE_FULL;
    int          recv_hold    = 0;
    int          strings_sent = 0;
    int          random_items = 0;
    logic        opening;
    logic [5:0]  open_base;
    logic [7:0]  ws_chars [3] = '{CH_SPACE, CH_TAB, CH_NL};

    unsigned_number_text_parser_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .ch          (ch),
        .first       (first),
        .base_req    (base_req),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value),
        .stop_offset (stop_offset),
        .done_res    (done_res),
        .base_used   (base_used)
    );

    unstp_parse_monitor parse_watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ch           (ch),
        .first        (first),
        .base_req     (base_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value        (value),
        .stop_offset  (stop_offset),
        .done_res     (done_res),
        .base_used    (base_used),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int draw_wait();
        case (idle_mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 15);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
        endcase
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10)
            return CH_ZERO + 8'(d);
        if ($urandom_range(0, 1) == 1)
            return CH_LA + 8'(d - 10);
        return CH_UA + 8'(d - 10);
    endfunction

    // Offer one transaction and hold it until the parser takes it.
    task automatic send_char(input logic [7:0] c, input logic f, input logic [5:0] b);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        first    <= f;
        base_req <= b;
        if (f)
            strings_sent++;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic emit_char(input logic [7:0] c);
        send_char(c, opening, opening ? open_base : 6'($urandom_range(0, 63)));
        opening = 1'b0;
        random_items++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic send_random_string();
        logic [5:0] b;
        int         eff;
        int         prefix;
        int         ndig;
        case ($urandom_range(0, 7))
            0, 1:    b = BASE_AUTO;
            2:       b = BASE_DEC;
            3:       b = BASE_HEX;
            4:       b = BASE_OCT;
            5:       b = 6'd2;
            6:       b = 6'($urandom_range(1, 36));
            default: b = 6'($urandom_range(0, 63));
        endcase
        opening   = 1'b1;
        open_base = b;
        if ($urandom_range(0, 9) == 0)
        begin
            // noise: random bytes, now and then restarting mid-string
            repeat ($urandom_range(1, 8))
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    opening   = 1'b1;
                    open_base = 6'($urandom_range(0, 63));
                end
                emit_char(8'($urandom));
            end
            return;
        end
        repeat ($urandom_range(0, 3))
            emit_char(ws_chars[$urandom_range(0, 2)]);
        eff    = (b == BASE_AUTO) ? 10 : ((b > 6'd36) ? 36 : int'(b));
        prefix = 0;
        if (b == BASE_AUTO || b == BASE_HEX)
        begin
            prefix = $urandom_range(0, 2);
            if (prefix != 0)
                emit_char(CH_ZERO);
            if (prefix == 1)
            begin
                emit_char(($urandom_range(0, 1) == 1) ? CH_LX : CH_UX);
                if (b == BASE_AUTO)
                    eff = 16;
            end
            else if (prefix == 2 && b == BASE_AUTO)
                eff = 8;
        end
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 6);
        for (int i = 0; i < ndig; i++)
            // keep plain auto strings decimal: a leading zero would turn them octal
            emit_char(digit_char((b == BASE_AUTO && prefix == 0 && i == 0) ?
                                 $urandom_range(1, 9) : $urandom_range(0, eff - 1)));
        case ($urandom_range(0, 9))
            0:          ;
            1, 2, 3, 4: emit_char(8'h00);
            default:    emit_char(8'($urandom));
        endcase
        // bytes past the end of the number
        repeat ($urandom_range(0, 2))
            send_char(8'($urandom), 1'b0, 6'($urandom));
    endtask

    initial
    begin : result_sink
        int n;
        @(posedge rst_n);
        forever
        begin
            if (recv_hold > 0)
            begin
                n         = recv_hold;
                recv_hold = 0;
            end
            else
                n = draw_wait();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No start flag after reset: auto base, tab, hex prefix, stop on a letter past f
        send_char(CH_TAB, 1'b0, BASE_AUTO);
        send_char(CH_ZERO, 1'b0, BASE_AUTO);
        send_char(CH_LX, 1'b0, BASE_AUTO);
        send_char(CH_UA + 8'd5, 1'b0, BASE_AUTO);
        send_char(CH_LZ, 1'b0, BASE_AUTO);
        // lone leading zero turns auto into octal, 8 stops it
        send_char(CH_ZERO, 1'b1, BASE_AUTO);
        send_char(CH_ZERO + 8'd7, 1'b0, BASE_AUTO);
        send_char(CH_ZERO + 8'd8, 1'b0, BASE_AUTO);
        // hex prefix with no digits after it
        send_char(CH_ZERO, 1'b1, BASE_HEX);
        send_char(CH_UX, 1'b0, BASE_AUTO);
        send_char(8'h00, 1'b0, BASE_AUTO);
        // terminator before any digit, after whitespace and after a lone zero
        send_char(CH_NL, 1'b1, BASE_AUTO);
        send_char(8'h00, 1'b0, BASE_AUTO);
        send_char(CH_ZERO, 1'b1, BASE_AUTO);
        send_char(8'h00, 1'b0, BASE_AUTO);
        // base 1 takes only zeros
        send_char(CH_ZERO, 1'b1, 6'd1);
        send_char(CH_ZERO, 1'b0, 6'd1);
        send_char(CH_ZERO + 8'd1, 1'b0, 6'd1);
        // top digits in base 36, all-ones byte stops it
        send_char(CH_LZ, 1'b1, 6'd36);
        send_char(CH_UZ, 1'b0, BASE_AUTO);
        send_char(CH_NINE, 1'b0, BASE_AUTO);
        send_char(8'hFF, 1'b0, 6'd63);
        // widest base, then a byte after done
        send_char(CH_SPACE, 1'b1, 6'd63);
        send_char(CH_UZ, 1'b0, BASE_AUTO);
        send_char(CH_LZ, 1'b0, BASE_AUTO);
        send_char(8'h21, 1'b0, BASE_AUTO);
        send_char(CH_LA, 1'b0, 6'd63);
        wait_drained();

        // Hold the result side off while the sender keeps pushing.
        idle_mode = IDLE_NONE;
        recv_hold = 120;
        repeat (8)
            send_random_string();
        wait_drained();

        for (int round = 0; round < 4; round++)
        begin
            idle_mode = idle_mode_t'(round % 3);
            while (random_items < (round + 1) * ROUND_ITEMS)
                send_random_string();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d results over %0d strings: auto, octal, hex and odd bases,",
                 results_seen, strings_sent);
        $display("prefix corners, 64-bit wrap and long output back-pressure.");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
